// File: hw/rtl/balanced_modular_exponentiation_core_macros.svh
`ifndef BALANCED_MODULAR_EXPONENTIATION_CORE_MACROS_SVH
`define BALANCED_MODULAR_EXPONENTIATION_CORE_MACROS_SVH
// assertion checked while out of reset
`define BME_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// assertion checked at every rising clock edge
`define BME_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// File: hw/rtl/bme_pkg.sv
`default_nettype none
package bme_pkg;
    localparam int EXP_WIDTH = 32;
    localparam int IDX_WIDTH = 5;
    localparam int LEN_WIDTH = 6;
    localparam int OUT_WIDTH = 32;

    localparam logic DIV_SRC_BASE = 1'b0;
    localparam logic DIV_SRC_PROD = 1'b1;
    localparam logic MUL_SQUARE   = 1'b0;
    localparam logic MUL_WALK     = 1'b1;

    typedef struct packed {
        logic load;
        logic div_start;
        logic div_src;
        logic mul;
        logic mul_sel;
        logic sq_write;
        logic acc_write;
        logic idx_inc;
        logic idx_dec;
        logic out_load;
    } bme_cmd_t;

    typedef struct packed {
        logic exp_zero;
        logic mod_zero;
        logic div_done;
        logic last_sq;
        logic bit_set;
        logic idx_zero;
    } bme_stat_t;

    function automatic logic [LEN_WIDTH-1:0] bme_bit_len(input logic [EXP_WIDTH-1:0] e);
        logic [LEN_WIDTH-1:0] n;
        n = '0;
        for (int i = 0; i < EXP_WIDTH; i++) begin
            if (e[i]) begin
                n = LEN_WIDTH'(i + 1);
            end
        end
        return n;
    endfunction
endpackage
`default_nettype wire

// File: hw/rtl/bme_dpath.sv
`default_nettype none
module bme_dpath import bme_pkg::*; #(
    parameter int W = 32
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire bme_cmd_t             cmd,
    output bme_stat_t                 stat,
    input  wire logic [OUT_WIDTH-1:0] in_base,
    input  wire logic [EXP_WIDTH-1:0] in_exp,
    input  wire logic [OUT_WIDTH-1:0] in_mod,
    output logic [OUT_WIDTH-1:0]      residue
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]          b_reg, m_reg;
    logic [EXP_WIDTH-1:0]  e_reg;
    logic [LEN_WIDTH-1:0]  len_reg;
    logic [IDX_WIDTH-1:0]  idx_reg;
    logic signed [W-1:0]   acc_reg, sq_last_reg, rd_reg;
    logic signed [W-1:0]   sq_mem [EXP_WIDTH];
    logic signed [2*W-1:0] prod_reg;
    logic [2*W-1:0]        dvd_reg;
    logic [W-1:0]          rem_reg;
    logic                  neg_reg, busy_reg, done_reg;
    logic [CW-1:0]         cnt_reg;
    logic [OUT_WIDTH-1:0]  res_reg;

    logic signed [W-1:0]   opa, opb;
    logic [W:0]            t1, t2;
    logic [W-1:0]          r1, r2;
    logic signed [W+1:0]   rs, half, mext;
    logic signed [W-1:0]   bal;

    always_comb begin
        opa = (cmd.mul_sel == MUL_WALK) ? acc_reg : sq_last_reg;
        opb = (cmd.mul_sel == MUL_WALK) ? rd_reg : sq_last_reg;
        t1 = {rem_reg, dvd_reg[2*W-1]};
        r1 = (t1 >= {1'b0, m_reg}) ? W'(t1 - {1'b0, m_reg}) : t1[W-1:0];
        t2 = {r1, dvd_reg[2*W-2]};
        r2 = (t2 >= {1'b0, m_reg}) ? W'(t2 - {1'b0, m_reg}) : t2[W-1:0];
        mext = $signed({2'b00, m_reg});
        half = $signed({3'b000, m_reg[W-1:1]});
        rs = neg_reg ? -$signed({2'b00, rem_reg}) : $signed({2'b00, rem_reg});
        if (rs > half) begin
            rs = rs - mext;
        end
        if (rs < -half) begin
            rs = rs + mext;
        end
        bal = rs[W-1:0];
    end

    always_ff @(posedge aclk) begin
        rd_reg <= sq_mem[idx_reg];
        if (cmd.sq_write) begin
            sq_mem[idx_reg] <= bal;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            b_reg   <= in_base[W-1:0];
            m_reg   <= in_mod[W-1:0];
            e_reg   <= in_exp;
            len_reg <= bme_bit_len(in_exp);
            acc_reg <= (in_mod[W-1:0] == '0) ? '0 : W'(1);
        end
        if (cmd.mul) begin
            prod_reg <= (2*W)'(opa) * (2*W)'(opb);
        end
        if (cmd.sq_write) begin
            sq_last_reg <= bal;
        end
        if (cmd.acc_write) begin
            acc_reg <= bal;
        end
        if (cmd.out_load) begin
            res_reg <= OUT_WIDTH'(acc_reg);
        end
        if (cmd.div_start) begin
            rem_reg <= '0;
            if (cmd.div_src == DIV_SRC_PROD) begin
                neg_reg <= prod_reg[2*W-1];
                dvd_reg <= prod_reg[2*W-1] ? (2*W)'(-prod_reg) : prod_reg;
            end else begin
                neg_reg <= 1'b0;
                dvd_reg <= {{W{1'b0}}, b_reg};
            end
        end else if (busy_reg) begin
            rem_reg <= r2;
            dvd_reg <= {dvd_reg[2*W-3:0], 2'b00};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (cmd.load) begin
                idx_reg <= '0;
            end else if (cmd.idx_inc) begin
                idx_reg <= idx_reg + 1'b1;
            end else if (cmd.idx_dec) begin
                idx_reg <= idx_reg - 1'b1;
            end
            if (cmd.div_start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        stat.exp_zero = (len_reg == '0);
        stat.mod_zero = (m_reg == '0);
        stat.div_done = done_reg;
        stat.last_sq  = (LEN_WIDTH'(idx_reg) + 1'b1 == len_reg);
        stat.bit_set  = e_reg[idx_reg];
        stat.idx_zero = (idx_reg == '0);
    end

    assign residue = res_reg;
endmodule
`default_nettype wire

// File: hw/rtl/bme_ctrl.sv
`default_nettype none
module bme_ctrl import bme_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  wire logic      m_ready,
    input  wire bme_stat_t stat,
    output bme_cmd_t       cmd
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHK   = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_DSTRT = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_WREAD = 3'd5;
    localparam logic [2:0] S_WTEST = 3'd6;
    localparam logic [2:0] S_FIN   = 3'd7;

    logic [2:0] state_reg, state_next;
    logic       walk_reg, walk_next;
    logic       m_valid_reg, m_valid_next;

    always_comb begin
        state_next   = state_reg;
        walk_next    = walk_reg;
        m_valid_next = m_valid_reg;
        cmd          = '0;
        cmd.mul_sel  = walk_reg ? MUL_WALK : MUL_SQUARE;
        cmd.div_src  = DIV_SRC_PROD;
        s_ready      = (state_reg == S_IDLE);
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_CHK;
                end
            end
            S_CHK: begin
                if (stat.exp_zero || stat.mod_zero) begin
                    state_next = S_FIN;
                end else begin
                    cmd.div_start = 1'b1;
                    cmd.div_src   = DIV_SRC_BASE;
                    walk_next     = 1'b0;
                    state_next    = S_DIV;
                end
            end
            S_MUL: begin
                cmd.mul    = 1'b1;
                state_next = S_DSTRT;
            end
            S_DSTRT: begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV: begin
                if (stat.div_done) begin
                    if (walk_reg) begin
                        cmd.acc_write = 1'b1;
                        if (stat.idx_zero) begin
                            state_next = S_FIN;
                        end else begin
                            cmd.idx_dec = 1'b1;
                            state_next  = S_WREAD;
                        end
                    end else begin
                        cmd.sq_write = 1'b1;
                        if (stat.last_sq) begin
                            walk_next  = 1'b1;
                            state_next = S_WREAD;
                        end else begin
                            cmd.idx_inc = 1'b1;
                            state_next  = S_MUL;
                        end
                    end
                end
            end
            S_WREAD: begin
                state_next = S_WTEST;
            end
            S_WTEST: begin
                if (stat.bit_set) begin
                    state_next = S_MUL;
                end else if (stat.idx_zero) begin
                    state_next = S_FIN;
                end else begin
                    cmd.idx_dec = 1'b1;
                    state_next  = S_WREAD;
                end
            end
            S_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            walk_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            walk_reg    <= walk_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;
endmodule
`default_nettype wire

// File: hw/rtl/balanced_modular_exponentiation_core.sv
// balanced modular exponentiation core
// input channel s_*: base, exponent and modulus, one transaction per request;
// only the low MOD_WIDTH bits of base and modulus are used
// output channel m_*: the residue base^exponent mod modulus, balanced into
// [-floor(m/2), floor(m/2)], two's complement
// a request first builds one squaring per exponent bit up to the highest set
// bit, then walks the bits from high to low and multiplies in each set one
// every modular multiply runs a multiply step, a start step and a remainder
// unit taking two dividend bits per cycle, then ends on a done pulse
// zero exponent or zero modulus goes straight from the check to the finish
// one request is in flight at a time; s_ready is high only while idle
// a finished result sits in the output register while the next request is
// taken; if the receiver stalls, the next result waits until it drains
// reset clears the controller and drops m_valid
`default_nettype none
module balanced_modular_exponentiation_core import bme_pkg::*; #(
    parameter int MOD_WIDTH = 32
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [OUT_WIDTH-1:0] s_base_value,
    input  wire logic [EXP_WIDTH-1:0] s_exponent,
    input  wire logic [OUT_WIDTH-1:0] s_modulus,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [OUT_WIDTH-1:0]      m_residue
);
    bme_cmd_t  cmd;
    bme_stat_t stat;

    bme_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    bme_dpath #(.W(MOD_WIDTH)) u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .stat    (stat),
        .in_base (s_base_value),
        .in_exp  (s_exponent),
        .in_mod  (s_modulus),
        .residue (m_residue)
    );
endmodule
`default_nettype wire

// File: hw/rtl/bme_checker.sv
`default_nettype none
`include "balanced_modular_exponentiation_core_macros.svh"
module bme_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [31:0] m_residue
);
    `BME_ASSERT(a_busy_after_accept, aclk, aresetn, (s_valid && s_ready) |=> !s_ready, "ready after transaction")
    `BME_ASSERT(a_result_held, aclk, aresetn, (m_valid && !m_ready) |=> (m_valid && $stable(m_residue)), "stalled result changed")
    `BME_ASSERT(a_no_result_on_accept, aclk, aresetn, (s_valid && s_ready && !m_valid) |=> !m_valid, "result too early")
    `BME_ASSERT_ALWAYS(a_reset_drops_valid, aclk, !aresetn |=> !m_valid, "valid after reset")
endmodule

bind balanced_modular_exponentiation_core bme_checker u_bme_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_residue (m_residue)
);
`default_nettype wire

// File: verif/tb_balanced_modular_exponentiation_core.sv
`default_nettype none
module tb_balanced_modular_exponentiation_core;
    timeunit 1ns;
    timeprecision 1ps;
    import bme_pkg::*;

    typedef struct packed {
        logic [OUT_WIDTH-1:0] base_value;
        logic [EXP_WIDTH-1:0] exponent;
        logic [OUT_WIDTH-1:0] modulus;
    } pow_req_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [OUT_WIDTH-1:0] s_base_value = '0;
    logic [EXP_WIDTH-1:0] s_exponent = '0;
    logic [OUT_WIDTH-1:0] s_modulus = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [OUT_WIDTH-1:0] m_residue;

    pow_req_t             pending_reqs[$];
    logic [OUT_WIDTH-1:0] expected_residues[$];
    int                   error_count = 0;
    bit                   calm = 1'b0;
    bit                   hold_off = 1'b0;

    always #1 aclk = ~aclk;

    balanced_modular_exponentiation_core #(.MOD_WIDTH(32)) i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_base_value(s_base_value), .s_exponent(s_exponent), .s_modulus(s_modulus),
        .m_valid(m_valid), .m_ready(m_ready), .m_residue(m_residue)
    );

    function automatic longint fold_high(longint v, longint m);
        if (v > m / 2) v -= m;
        return v;
    endfunction

    function automatic logic [OUT_WIDTH-1:0] balanced_power(pow_req_t r);
        longint sq[32];
        longint m;
        longint acc;
        int     nbits;
        m = longint'({32'd0, r.modulus});
        acc = 1;
        nbits = 0;
        if (m == 0) return '0;
        for (int i = 0; i < 32; i++) if (r.exponent[i]) nbits = i + 1;
        if (nbits == 0) return OUT_WIDTH'(1);
        sq[0] = fold_high(longint'({32'd0, r.base_value}) % m, m);
        for (int i = 1; i < nbits; i++) sq[i] = fold_high((sq[i-1] * sq[i-1]) % m, m);
        for (int i = nbits - 1; i >= 0; i--) begin
            if (r.exponent[i]) begin
                acc = (acc * sq[i]) % m;
                if (acc > m / 2) acc -= m;
                if (acc < -(m / 2)) acc += m;
            end
        end
        return acc[OUT_WIDTH-1:0];
    endfunction

    function automatic pow_req_t make_req(logic [31:0] b, logic [31:0] e, logic [31:0] m);
        pow_req_t r;
        r.base_value = b;
        r.exponent = e;
        r.modulus = m;
        return r;
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (pending_reqs.size() > 0 && (calm || $urandom_range(99) >= 30)) begin
                pow_req_t r;
                r = pending_reqs.pop_front();
                s_valid <= 1'b1;
                s_base_value <= r.base_value;
                s_exponent <= r.exponent;
                s_modulus <= r.modulus;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // predict each accepted transaction
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            expected_residues.push_back(balanced_power(make_req(s_base_value, s_exponent,
                                                                s_modulus)));
    end

    // receiver and checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_residues.size() == 0) begin
                $error("unexpected transaction residue %h", m_residue);
                error_count++;
            end else begin
                logic [OUT_WIDTH-1:0] exp_res;
                exp_res = expected_residues.pop_front();
                if (m_residue !== exp_res) begin
                    $error("residue expected %h actual %h", exp_res, m_residue);
                    error_count++;
                end
            end
        end
        m_ready <= aresetn && !hold_off && (calm || $urandom_range(99) >= 30);
    end

    function automatic logic [31:0] rand_mod();
        case ($urandom_range(3))
            0: return $urandom_range(2, 20);
            1: return $urandom_range(2, 65535);
            2: return 32'hFFFF_FFF0 | 32'($urandom_range(15));
            default: return $urandom;
        endcase
    endfunction

    initial begin
        logic [31:0] m;
        pending_reqs.push_back(make_req(5, 0, 7));
        pending_reqs.push_back(make_req(5, 0, 0));
        pending_reqs.push_back(make_req(5, 3, 0));
        pending_reqs.push_back(make_req(9, 7, 1));
        pending_reqs.push_back(make_req(9, 0, 1));
        pending_reqs.push_back(make_req(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        pending_reqs.push_back(make_req(32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFB));
        pending_reqs.push_back(make_req(3, 32'h8000_0000, 32'h7FFF_FFFF));
        pending_reqs.push_back(make_req(1000, 1, 7));
        pending_reqs.push_back(make_req(3, 1, 6));
        pending_reqs.push_back(make_req(3, 3, 6));
        pending_reqs.push_back(make_req(5, 2, 10));
        pending_reqs.push_back(make_req(0, 12345, 97));
        pending_reqs.push_back(make_req(2, 10, 2));
        pending_reqs.push_back(make_req(32'h8000_0001, 32'h5555_5555, 32'hAAAA_AAAA));
        pending_reqs.push_back(make_req(7, 32'hAAAA_AAAA, 32'h8000_0000));
        pending_reqs.push_back(make_req(32'h1234_5678, 65537, 32'hFFFF_FFC5));
        for (int i = 0; i < 255; i++) begin
            m = rand_mod();
            case ($urandom_range(9))
                0: pending_reqs.push_back(make_req($urandom, $urandom, m));
                1: pending_reqs.push_back(make_req($urandom, $urandom_range(15), m));
                2: pending_reqs.push_back(make_req($urandom, $urandom, $urandom_range(1)));
                default: pending_reqs.push_back(make_req($urandom % m, $urandom, m));
            endcase
        end
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        while (pending_reqs.size() > 200) @(posedge aclk);
        hold_off = 1'b1;
        repeat (6000) @(posedge aclk);
        hold_off = 1'b0;
        while (pending_reqs.size() > 120) @(posedge aclk);
        calm = 1'b1;
        while (pending_reqs.size() > 60) @(posedge aclk);
        calm = 1'b0;
        while (pending_reqs.size() > 0 || s_valid || expected_residues.size() > 0)
            @(posedge aclk);
        repeat (1500) @(posedge aclk);
        if (error_count == 0 && expected_residues.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #10000000;
        $display("TB_ERROR");
        $finish;
    end
endmodule
`default_nettype wire

// File: files.f
+incdir+hw/rtl
hw/rtl/bme_pkg.sv
hw/rtl/bme_dpath.sv
hw/rtl/bme_ctrl.sv
hw/rtl/balanced_modular_exponentiation_core.sv
hw/rtl/bme_checker.sv
verif/tb_balanced_modular_exponentiation_core.sv
